>>> rtl/core/mcetc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mcetc_pkg;

  localparam int PIN_W   = 8;
  localparam int CHAN_W  = 3;
  localparam int COUNT_W = 16;
  localparam int TIME_W  = 24;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PIN_W-1:0] sensor_pins;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [COUNT_W-1:0] edge_count;
    logic [TIME_W-1:0]  edge_time;
    logic               last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;   // item transaction completes this cycle
    logic emit;        // load next result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tick_edges;    // current item is a racing tick with at least one edge
    logic last_pending;  // only one edge left to report
    logic slot_free;     // output register can take a new result
  } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/mcetc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mcetc_ctrl (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    item_valid,
  output logic                   item_stall,
  input  mcetc_pkg::dp_status_t  status,
  output mcetc_pkg::ctrl_cmd_t   cmd
);
  import mcetc_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t state;

  assign item_stall    = (state == S_SCAN);
  assign cmd.take_item = item_valid && (state == S_IDLE);
  assign cmd.emit      = (state == S_SCAN) && status.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.take_item && status.tick_edges) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmd.emit && status.last_pending) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mcetc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module mcetc_datapath #(
  parameter int CHANNELS = 8
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           config_valid,
  input  wire  [mcetc_pkg::PIN_W-1:0]   config_data,
  input  mcetc_pkg::item_t              item,
  input  mcetc_pkg::ctrl_cmd_t          cmd,
  output mcetc_pkg::dp_status_t         status,
  output logic                          result_valid,
  input  wire                           result_stall,
  output mcetc_pkg::result_t            result
);
  import mcetc_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic                racing;
  logic [TIME_W-1:0]   elapsed_ms;
  logic [PIN_W-1:0]    previous_pins;
  logic [PIN_W-1:0]    active_mask;
  logic [COUNT_W-1:0]  channel_counts [CHANNELS];
  logic [CHANNELS-1:0] pending;

  logic [CHANNELS-1:0] rose;
  logic [CHANNELS-1:0] pending_next;
  logic [CH_W-1:0]     sel;
  logic [COUNT_W-1:0]  count_next;

  // channels past the pin width never rise
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < PIN_W) begin
        rose[c] = item.sensor_pins[c % PIN_W] & ~previous_pins[c % PIN_W]
                  & active_mask[c % PIN_W];
      end else begin
        rose[c] = 1'b0;
      end
    end
  end

  // lowest pending channel first
  always_comb begin
    sel = '0;
    for (int c = CHANNELS - 1; c >= 0; c--) begin
      if (pending[c]) begin
        sel = CH_W'(c);
      end
    end
  end

  always_comb begin
    pending_next      = pending;
    pending_next[sel] = 1'b0;
  end

  assign count_next = channel_counts[sel] + COUNT_W'(1);

  assign status.tick_edges   = (item.operation == OP_TICK) && racing && (|rose);
  assign status.last_pending = ~(|pending_next);
  assign status.slot_free    = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      racing        <= 1'b0;
      elapsed_ms    <= '0;
      previous_pins <= '0;
      active_mask   <= '0;
      pending       <= '0;
      result_valid  <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        channel_counts[c] <= '0;
      end
    end else begin
      if (config_valid) begin
        active_mask <= config_data;
      end

      if (cmd.take_item) begin
        unique case (item.operation)
          OP_START: begin
            racing     <= 1'b1;
            elapsed_ms <= '0;
          end
          OP_STOP: begin
            racing <= 1'b0;
          end
          OP_TICK: begin
            if (racing) begin
              elapsed_ms    <= elapsed_ms + TIME_W'(1);
              previous_pins <= item.sensor_pins;
              pending       <= rose;
            end
          end
          default: ;
        endcase
      end

      if (cmd.emit) begin
        channel_counts[sel] <= count_next;
        pending             <= pending_next;
        result_valid        <= 1'b1;
      end else if (status.slot_free) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.channel    <= CHAN_W'(sel);
      result.edge_count <= count_next;
      result.edge_time  <= elapsed_ms;
      result.last       <= status.last_pending;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/multi_channel_edge_tick_capture_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// item      in         item_valid/item_stall   item_t   (operation, sensor_pins)
// result    out        result_valid/result_stall result_t (channel, count, time, last)
// config    in         config_valid/config_ready config_data (active mask)
//
// Start, stop, spare codes and ticks without a rising edge keep the controller idle.
// A racing tick with rising edges starts a scan: one result per cycle unless result
// stalls, set by the single shared count incrementer walking the pending edge mask.
// rst is synchronous: stopped, time, last sample, mask and counts cleared.
// A stall on result freezes the scan; item is stalled while a scan runs.

module multi_channel_edge_tick_capture_unit #(
  parameter int CHANNELS = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          item_valid,
  output logic                         item_stall,
  input  mcetc_pkg::item_t             item,
  output logic                         result_valid,
  input  wire                          result_stall,
  output mcetc_pkg::result_t           result,
  input  wire                          config_valid,
  output logic                         config_ready,
  input  wire  [mcetc_pkg::PIN_W-1:0]  config_data
);
  import mcetc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // mask write is registered, always accepted
  assign config_ready = 1'b1;

  mcetc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mcetc_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .config_valid (config_valid),
    .config_data  (config_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

>>> bench/edge_report_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and config channels, predicts the edge reports
// and compares each completed result transaction with the oldest prediction.
module edge_report_checker
  import mcetc_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  input  wire                 item_stall,
  input  item_t               item,
  input  wire                 result_valid,
  input  wire                 result_stall,
  input  result_t             result,
  input  wire                 config_valid,
  input  wire                 config_ready,
  input  wire  [PIN_W-1:0]    config_data,
  output int                  mismatches,
  output int                  reports_due
);

  logic [PIN_W-1:0]   channel_mask;
  logic [PIN_W-1:0]   prior_pins;
  logic               racing;
  logic [TIME_W-1:0]  race_ms;
  logic [COUNT_W-1:0] edge_totals [PIN_W];
  logic [TIME_W-1:0]  edge_stamps [PIN_W];
  result_t            pending_reports [$];
  result_t            oldest;
  int                 errors = 0;

  task automatic predict_edge_reports(input item_t it);
    logic [PIN_W-1:0] rose;
    result_t          rep;
    case (it.operation)
      OP_START: begin
        racing  = 1'b1;
        race_ms = '0;
      end
      OP_STOP: racing = 1'b0;
      OP_TICK: begin
        if (racing) begin
          race_ms    = race_ms + 1'b1;
          rose       = it.sensor_pins & ~prior_pins & channel_mask;
          prior_pins = it.sensor_pins;
          for (int c = 0; c < PIN_W; c++) begin
            if (rose[c]) begin
              edge_totals[c] = edge_totals[c] + 1'b1;
              edge_stamps[c] = race_ms;
              rep.channel    = CHAN_W'(c);
              rep.edge_count = edge_totals[c];
              rep.edge_time  = edge_stamps[c];
              // final report of this tick: no higher channel rose
              rep.last       = ((rose >> (c + 1)) == '0);
              pending_reports.push_back(rep);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      channel_mask = '0;
      prior_pins   = '0;
      racing       = 1'b0;
      race_ms      = '0;
      for (int c = 0; c < PIN_W; c++) begin
        edge_totals[c] = '0;
        edge_stamps[c] = '0;
      end
      pending_reports.delete();
    end else begin
      if (config_valid && config_ready)
        channel_mask = config_data;
      // retire before predicting, so a fresh prediction never meets a stale result
      if (result_valid && !result_stall) begin
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t ns: report expected none, got channel %0d count %0d time %0d",
                   $time, result.channel, result.edge_count, result.edge_time);
        end else begin
          oldest = pending_reports.pop_front();
          check_field("channel", 32'(oldest.channel), 32'(result.channel));
          check_field("edge_count", 32'(oldest.edge_count), 32'(result.edge_count));
          check_field("edge_time", 32'(oldest.edge_time), 32'(result.edge_time));
          check_field("last", 32'(oldest.last), 32'(result.last));
        end
      end
      if (item_valid && !item_stall)
        predict_edge_reports(item);
    end
    mismatches  <= errors;
    reports_due <= pending_reports.size();
  end

endmodule

>>> bench/tb_multi_channel_edge_tick_capture_unit.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the edge capture unit. Prediction and comparison
// live in edge_report_checker, which sits beside the block and reports back
// its mismatch count and the number of reports still owed.
module tb_multi_channel_edge_tick_capture_unit;
  import mcetc_pkg::*;

  // spare operation code, must be ignored by the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_LIMIT   = 2000;   // cycles with no transaction at all
  localparam int SETTLE       = 12;     // lets a last scan of reports finish
  localparam int PHASE_ITEMS  = 53;
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
  localparam int TOGGLE_PAIRS = 4;      // back-to-back rise/fall pairs at the end

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  item_t             item         = '0;
  logic              item_stall;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              config_valid = 1'b0;
  logic              config_ready;
  logic [PIN_W-1:0]  config_data  = '0;

  int                mismatches;
  int                reports_due;

  // quiet: no idling on either side; hold_off: asks the receiver for its long hold
  logic              quiet        = 1'b0;
  logic              hold_off     = 1'b0;
  int                gap_odds     = 8;     // 1 in gap_odds items preceded by a gap, 0 = never
  logic [PIN_W-1:0]  last_pins    = '0;
  int                idle_cycles  = 0;

  always #10 clk = ~clk;

  multi_channel_edge_tick_capture_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .config_valid (config_valid),
    .config_ready (config_ready),
    .config_data  (config_data)
  );

  edge_report_checker u_report_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .config_valid (config_valid),
    .config_ready (config_ready),
    .config_data  (config_data),
    .mismatches   (mismatches),
    .reports_due  (reports_due)
  );

  // Offer one item and return at the edge where its transaction completes.
  // Valid is left high so back-to-back items need no second assignment.
  task automatic send_item(input logic [1:0] op, input logic [PIN_W-1:0] pins);
    if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item       <= '{operation: op, sensor_pins: pins};
    item_valid <= 1'b1;
    if (op == OP_TICK)
      last_pins = pins;
    // item_stall read here is its value at the edge just passed
    do @(posedge clk); while (item_stall);
  endtask

  // Mostly ticks while racing, with the odd start, stop and spare code.
  // Inverted pins force edges on every channel that was low.
  task automatic send_random;
    int               pick;
    logic [PIN_W-1:0] pins;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0, 1:    pins = PIN_W'($urandom_range(0, 255));
      2:       pins = ~last_pins;
      default: pins = '0;
    endcase
    if (pick < 78)
      send_item(OP_TICK, pins);
    else if (pick < 86)
      send_item(OP_START, pins);
    else if (pick < 93)
      send_item(OP_STOP, pins);
    else
      send_item(OP_UNUSED, pins);
  endtask

  // Drop valid, wait for every owed report, then let a last scan finish.
  // reports_due is registered, hence the short wait before polling.
  task automatic settle;
    item_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (reports_due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mask(input logic [PIN_W-1:0] mask);
    settle();
    config_data  <= mask;
    config_valid <= 1'b1;
    do @(posedge clk); while (!config_ready);
    config_valid <= 1'b0;
  endtask

  // Receiver: random stall bursts, clean stretches, and one long hold-off
  // while the sender keeps pushing edge-heavy ticks.
  initial begin : receiver
    logic held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off && !held) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        result_stall <= 1'b0;
      end else if ($urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any transaction on any channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (config_valid && config_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("multi_channel_edge_tick_capture_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [PIN_W-1:0] mask;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: all channels counted
    write_mask(8'hFF);
    send_item(OP_TICK, 8'hFF);     // tick while stopped, sample not taken
    send_item(OP_STOP, 8'h00);     // stop while stopped
    send_item(OP_UNUSED, 8'hFF);   // spare code while stopped
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'hFF);     // all eight rise at once
    send_item(OP_TICK, 8'hFF);     // held high, no edges
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h55);
    send_item(OP_TICK, 8'hAA);
    send_item(OP_UNUSED, 8'hFF);   // spare code while racing
    send_item(OP_START, 8'hFF);    // restart while racing: time cleared, counts kept
    send_item(OP_TICK, 8'hFF);
    send_item(OP_STOP, 8'h00);
    send_item(OP_TICK, 8'h00);     // stopped: previous sample must stay at FF
    send_item(OP_TICK, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h01);     // lowest channel alone
    send_item(OP_TICK, 8'h80);     // highest channel alone
    send_item(OP_STOP, 8'h00);

    // random phases, each under its own mask and sender idling
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       mask = 8'h00;
        1:       mask = 8'hFF;
        3:       mask = 8'h01;
        5:       mask = 8'h80;
        default: mask = PIN_W'($urandom_range(1, 254));
      endcase
      write_mask(mask);
      case (p % 3)
        0:       gap_odds = 0;
        1:       gap_odds = 8;
        default: gap_odds = 3;
      endcase
      send_item(OP_START, PIN_W'($urandom_range(0, 255)));
      if (p == 1) begin
        // back-pressure: receiver holds off, the block fills and stalls items
        hold_off <= 1'b1;
        for (int i = 0; i < 12; i++) begin
          send_item(OP_TICK, 8'hFF);
          send_item(OP_TICK, 8'h00);
        end
        hold_off <= 1'b0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random();
    end

    // last part, no idling: one channel toggles back to back
    write_mask(8'hFF);
    quiet = 1'b1;
    send_item(OP_START, 8'h00);
    for (int i = 0; i < TOGGLE_PAIRS; i++) begin
      send_item(OP_TICK, 8'h80);
      send_item(OP_TICK, 8'h00);
    end
    send_item(OP_STOP, 8'h00);
    settle();

    if (mismatches == 0 && reports_due == 0)
      $display("multi_channel_edge_tick_capture_unit: match");
    else
      $display("multi_channel_edge_tick_capture_unit: mismatch");
    $finish;
  end

endmodule
